// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the PDU responder.
// No dependencies; the caller provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mbpr_pkg.sv -----
// Types, constants and helper functions of the Modbus PDU responder.
// No dependencies.
package mbpr_pkg;

  localparam int REG_DEPTH      = 1024;
  localparam int COIL_DEPTH     = 4096;
  localparam int MAX_DATA_BYTES = 250;
  localparam int REG_AW         = $clog2(REG_DEPTH);
  localparam int COIL_AW        = $clog2(COIL_DEPTH);
  localparam int CLR_AW         = (COIL_AW > REG_AW) ? COIL_AW : REG_AW;
  localparam int CLR_DEPTH      = (COIL_DEPTH > REG_DEPTH) ? COIL_DEPTH : REG_DEPTH;

  localparam logic [15:0] COIL_LIMIT = 16'(MAX_DATA_BYTES * 8);
  localparam logic [15:0] REG_LIMIT  = 16'(MAX_DATA_BYTES / 2);

  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_INPUTS   = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUTREG = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
  localparam logic [7:0] FC_WRITE_REG     = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_PULL   = 2'd1,
    CMD_HWRITE = 2'd2,
    CMD_HREAD  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  data_byte;
    logic        request_last;
    logic        store_select;
    logic [11:0] entry_index;
    logic [15:0] entry_value;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        out_last;
    logic        response_ready;
    logic        bad_function;
    logic        quantity_clipped;
    logic [15:0] entry_read_value;
  } result_t;

  typedef struct packed {
    logic [1:0]         reg_we;
    logic [REG_AW-1:0]  reg_waddr;
    logic [15:0]        reg_wdata;
    logic [REG_AW-1:0]  reg_raddr;
    logic               coil_we;
    logic [COIL_AW-1:0] coil_waddr;
    logic               coil_wdata;
    logic [COIL_AW-1:0] coil_raddr;
  } store_req_t;

  function automatic logic fc_supported(logic [7:0] fc);
    return (fc >= FC_READ_COILS && fc <= FC_WRITE_REG) ||
           fc == FC_WRITE_COILS || fc == FC_WRITE_REGS;
  endfunction

  function automatic logic fc_is_coil(logic [7:0] fc);
    return fc == FC_READ_COILS || fc == FC_READ_INPUTS || fc == FC_WRITE_COILS;
  endfunction

endpackage

// ----- src/modbus_server_pdu_responder_unit.sv -----
// Top level of the Modbus server PDU responder: command sequencer and header state.
// Depends on mbpr_pkg, mbpr_stores and assert_macros.svh.
//
// After reset the block sweeps both stores to zero, one entry a cycle,
// with busy_o high. An item is taken when start_i is high and busy_o is low, and its
// result is shown on result_o for one cycle with done_o high; it cannot be held off.
// A header byte, a register data byte, a host write or an empty pull goes straight to
// S_DONE; a host read passes S_HRD, a register response byte S_PREG, the last request
// byte S_FIN; coil bytes loop in S_CWR or S_PCOIL, one coil store access per cycle.
`include "assert_macros.svh"

module modbus_server_pdu_responder_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mbpr_pkg::item_t   item_i,
  output logic              busy_o,
  output logic              done_o,
  output mbpr_pkg::result_t result_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CWR   = 4'd2;
  localparam logic [3:0] S_FIN   = 4'd3;
  localparam logic [3:0] S_PCOIL = 4'd4;
  localparam logic [3:0] S_PREG  = 4'd5;
  localparam logic [3:0] S_HRD   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0]  state_q, state_d;
  logic [mbpr_pkg::CLR_AW-1:0] clr_q, clr_d;
  mbpr_pkg::item_t item_q, item_d;
  logic [7:0]  hdr_q [7];
  logic [7:0]  hdr_d [7];
  logic [2:0]  rp_q, rp_d;
  logic [11:0] wp_q, wp_d;
  logic [7:0]  len_q, len_d, pos_q, pos_d;
  logic        bad_q, bad_d, clip_q, clip_d, rdy_q, rdy_d;
  logic [3:0]  j_q, j_d;
  logic [7:0]  d_q, d_d, acc_q, acc_d;
  logic        en_q, en_d;
  logic [7:0]  ob_q, ob_d;
  logic        ov_q, ov_d, ol_q, ol_d;
  logic [15:0] rv_q, rv_d;

  mbpr_pkg::store_req_t req;
  logic [15:0] reg_rdata;
  logic        coil_rdata;

  logic [7:0]  fc;
  logic [15:0] start_addr, qraw, qclip;
  logic        clipped;
  logic [10:0] e_bits;
  logic [15:0] coil_sum, reg_sum;
  logic [7:0]  kk;

  mbpr_stores u_stores (
    .clk_i        (clk_i),
    .req_i        (req),
    .reg_rdata_o  (reg_rdata),
    .coil_rdata_o (coil_rdata)
  );

  always_comb begin
    fc         = hdr_q[1];
    start_addr = {hdr_q[2], hdr_q[3]};
    qraw       = {hdr_q[4], hdr_q[5]};
    qclip      = qraw;
    clipped    = 1'b0;
    if (mbpr_pkg::fc_is_coil(fc)) begin
      if (qraw > mbpr_pkg::COIL_LIMIT) begin
        qclip   = mbpr_pkg::COIL_LIMIT;
        clipped = 1'b1;
      end
    end else if (fc == mbpr_pkg::FC_READ_HOLDING || fc == mbpr_pkg::FC_READ_INPUTREG ||
                 fc == mbpr_pkg::FC_WRITE_REGS) begin
      if (qraw > mbpr_pkg::REG_LIMIT) begin
        qclip   = mbpr_pkg::REG_LIMIT;
        clipped = 1'b1;
      end
    end
    e_bits   = {d_q, j_q[2:0]};
    coil_sum = start_addr + {5'd0, e_bits};
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    item_d  = item_q;
    hdr_d   = hdr_q;
    rp_d    = rp_q;
    wp_d    = wp_q;
    len_d   = len_q;
    pos_d   = pos_q;
    bad_d   = bad_q;
    clip_d  = clip_q;
    rdy_d   = rdy_q;
    j_d     = j_q;
    d_d     = d_q;
    acc_d   = acc_q;
    en_d    = en_q;
    ob_d    = ob_q;
    ov_d    = ov_q;
    ol_d    = ol_q;
    rv_d    = rv_q;
    req     = '0;
    kk      = pos_q - 8'd3;
    reg_sum = 16'd0;

    case (state_q)
      S_CLEAR: begin
        req.coil_we    = 1'b1;
        req.coil_waddr = clr_q[mbpr_pkg::COIL_AW-1:0];
        req.reg_we     = 2'b11;
        req.reg_waddr  = clr_q[mbpr_pkg::REG_AW-1:0];
        clr_d          = clr_q + 1'b1;
        if (clr_q == mbpr_pkg::CLR_AW'(mbpr_pkg::CLR_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          item_d  = item_i;
          ob_d    = 8'd0;
          ov_d    = 1'b0;
          ol_d    = 1'b0;
          rv_d    = 16'd0;
          state_d = S_DONE;
          case (item_i.cmd)
            mbpr_pkg::CMD_PUSH: begin
              if (rp_q == 3'd0 && wp_q == 12'd0) begin
                for (int i = 0; i < 7; i++) begin
                  hdr_d[i] = 8'd0;
                end
                rdy_d = 1'b0;
              end
              if (item_i.request_last) begin
                state_d = S_FIN;
              end
              if (rp_q != 3'd7) begin
                hdr_d[rp_q] = item_i.data_byte;
                rp_d        = rp_q + 1'b1;
              end else begin
                d_d = wp_q[7:0];
                if (wp_q != 12'hFFF) begin
                  wp_d = wp_q + 1'b1;
                end
                if (wp_q < {4'd0, hdr_q[6]}) begin
                  if (fc == mbpr_pkg::FC_WRITE_COILS) begin
                    j_d     = 4'd0;
                    state_d = S_CWR;
                  end else if (fc == mbpr_pkg::FC_WRITE_REGS &&
                               {5'd0, wp_q[11:1]} < qclip) begin
                    reg_sum        = start_addr + {5'd0, wp_q[11:1]};
                    req.reg_we     = wp_q[0] ? 2'b01 : 2'b10;
                    req.reg_waddr  = reg_sum[mbpr_pkg::REG_AW-1:0];
                    req.reg_wdata  = {item_i.data_byte, item_i.data_byte};
                  end
                end
              end
            end
            mbpr_pkg::CMD_PULL: begin
              if (rdy_q) begin
                ov_d  = 1'b1;
                pos_d = pos_q + 1'b1;
                if (pos_q + 8'd1 >= len_q) begin
                  ol_d  = 1'b1;
                  rdy_d = 1'b0;
                end
                if (pos_q < 8'd2) begin
                  ob_d = hdr_q[pos_q[2:0]];
                end else if (fc > mbpr_pkg::FC_READ_INPUTREG) begin
                  ob_d = (pos_q < 8'd6) ? hdr_q[pos_q[2:0]] : 8'd0;
                end else if (pos_q == 8'd2) begin
                  ob_d = len_q - 8'd3;
                end else begin
                  d_d = kk;
                  if (mbpr_pkg::fc_is_coil(fc)) begin
                    j_d     = 4'd0;
                    acc_d   = 8'd0;
                    en_d    = 1'b0;
                    state_d = S_PCOIL;
                  end else begin
                    reg_sum       = start_addr + {9'd0, kk[7:1]};
                    req.reg_raddr = reg_sum[mbpr_pkg::REG_AW-1:0];
                    state_d       = S_PREG;
                  end
                end
              end
            end
            mbpr_pkg::CMD_HWRITE: begin
              if (item_i.store_select) begin
                req.coil_we    = 1'b1;
                req.coil_waddr = item_i.entry_index[mbpr_pkg::COIL_AW-1:0];
                req.coil_wdata = item_i.entry_value[0];
              end else begin
                req.reg_we    = 2'b11;
                req.reg_waddr = item_i.entry_index[mbpr_pkg::REG_AW-1:0];
                req.reg_wdata = item_i.entry_value;
              end
            end
            mbpr_pkg::CMD_HREAD: begin
              req.coil_raddr = item_i.entry_index[mbpr_pkg::COIL_AW-1:0];
              req.reg_raddr  = item_i.entry_index[mbpr_pkg::REG_AW-1:0];
              state_d        = S_HRD;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_CWR: begin
        if ({5'd0, e_bits} < qclip) begin
          req.coil_we    = 1'b1;
          req.coil_waddr = coil_sum[mbpr_pkg::COIL_AW-1:0];
          req.coil_wdata = item_q.data_byte[j_q[2:0]];
        end
        j_d = j_q + 1'b1;
        if (j_q == 4'd7) begin
          state_d = item_q.request_last ? S_FIN : S_DONE;
        end
      end
      S_FIN: begin
        rp_d   = 3'd0;
        wp_d   = 12'd0;
        bad_d  = 1'b0;
        clip_d = 1'b0;
        rdy_d  = 1'b0;
        if (!mbpr_pkg::fc_supported(fc)) begin
          bad_d = 1'b1;
        end else begin
          clip_d = clipped;
          rdy_d  = 1'b1;
          pos_d  = 8'd0;
          if (fc <= mbpr_pkg::FC_READ_INPUTREG) begin
            if (mbpr_pkg::fc_is_coil(fc)) begin
              len_d = 8'd3 + 8'((qclip + 16'd7) >> 3);
            end else begin
              len_d = 8'd3 + 8'(qclip << 1);
            end
          end else begin
            len_d = 8'd6;
          end
        end
        state_d = S_DONE;
      end
      S_PCOIL: begin
        if (j_q != 4'd8) begin
          req.coil_raddr = coil_sum[mbpr_pkg::COIL_AW-1:0];
          en_d           = {5'd0, e_bits} < qclip;
        end
        if (j_q != 4'd0) begin
          acc_d = {coil_rdata & en_q, acc_q[7:1]};
        end
        j_d = j_q + 1'b1;
        if (j_q == 4'd8) begin
          ob_d    = {coil_rdata & en_q, acc_q[7:1]};
          state_d = S_DONE;
        end
      end
      S_PREG: begin
        ob_d    = d_q[0] ? reg_rdata[7:0] : reg_rdata[15:8];
        state_d = S_DONE;
      end
      S_HRD: begin
        rv_d    = item_q.store_select ? {15'd0, coil_rdata} : reg_rdata;
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      for (int i = 0; i < 7; i++) begin
        hdr_q[i] <= 8'd0;
      end
      rp_q   <= 3'd0;
      wp_q   <= 12'd0;
      len_q  <= 8'd0;
      pos_q  <= 8'd0;
      bad_q  <= 1'b0;
      clip_q <= 1'b0;
      rdy_q  <= 1'b0;
      j_q    <= 4'd0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hdr_q   <= hdr_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      bad_q   <= bad_d;
      clip_q  <= clip_d;
      rdy_q   <= rdy_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    d_q    <= d_d;
    acc_q  <= acc_d;
    en_q   <= en_d;
    ob_q   <= ob_d;
    ov_q   <= ov_d;
    ol_q   <= ol_d;
    rv_q   <= rv_d;
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;

  assign result_o.out_byte         = ob_q;
  assign result_o.out_valid        = ov_q;
  assign result_o.out_last         = ol_q;
  assign result_o.response_ready   = rdy_q;
  assign result_o.bad_function     = bad_q;
  assign result_o.quantity_clipped = clip_q;
  assign result_o.entry_read_value = rv_q;

  `ASSERT_NEXT(a_done_then_idle, done_o, !busy_o, "result not followed by idle")
  `ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted item did not raise busy")
  `ASSERT_ALWAYS(a_ready_not_bad, !(rdy_q && bad_q), "response pending after bad function")

endmodule

// ----- src/mbpr_stores.sv -----
// Holding register store and coil store of the PDU responder.
// Depends on mbpr_pkg; both memories have a registered read port.
module mbpr_stores (
  input  logic                clk_i,
  input  mbpr_pkg::store_req_t req_i,
  output logic [15:0]         reg_rdata_o,
  output logic                coil_rdata_o
);

  logic [15:0] reg_mem [mbpr_pkg::REG_DEPTH];
  logic        coil_mem [mbpr_pkg::COIL_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.reg_we[1]) begin
      reg_mem[req_i.reg_waddr][15:8] <= req_i.reg_wdata[15:8];
    end
    if (req_i.reg_we[0]) begin
      reg_mem[req_i.reg_waddr][7:0] <= req_i.reg_wdata[7:0];
    end
    reg_rdata_o <= reg_mem[req_i.reg_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.coil_we) begin
      coil_mem[req_i.coil_waddr] <= req_i.coil_wdata;
    end
    coil_rdata_o <= coil_mem[req_i.coil_raddr];
  end

endmodule

// ----- bench/tb_modbus_server_pdu_responder_unit.sv -----
// Self-checking testbench of modbus_server_pdu_responder_unit: directed table, then random
// request/pull/host traffic checked item by item against a behavioral model of the responder.
// Depends on mbpr_pkg and the RTL of the responder.
`timescale 1ns / 100ps

module tb_modbus_server_pdu_responder_unit;
  import mbpr_pkg::*;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start_i = 1'b0;
  item_t   item_i = '0;
  logic    busy_o;
  logic    done_o;
  result_t result_o;

  modbus_server_pdu_responder_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .item_i(item_i),
    .busy_o(busy_o), .done_o(done_o), .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  // Behavioral copy of the responder state.
  logic [15:0] hold_mem [REG_DEPTH];
  logic        coil_mem [COIL_DEPTH];
  logic [7:0]  hdr [7];
  int          hdr_pos;
  int          data_cnt;
  logic [7:0]  rsp_len;
  logic [7:0]  rsp_pos;
  logic        flag_bad, flag_clip, flag_ready;

  result_t     pending_q[$];
  int          mismatches = 0;
  int          sent = 0;
  int          burst_left = 0;

  function automatic logic bit_fc(logic [7:0] fc);
    return fc == FC_READ_COILS || fc == FC_READ_INPUTS || fc == FC_WRITE_COILS;
  endfunction

  function automatic logic known_fc(logic [7:0] fc);
    return (fc >= FC_READ_COILS && fc <= FC_WRITE_REG) ||
           fc == FC_WRITE_COILS || fc == FC_WRITE_REGS;
  endfunction

  function automatic int limited_qty(output logic clp);
    int q;
    q = {hdr[4], hdr[5]};
    clp = 1'b0;
    if (bit_fc(hdr[1])) begin
      if (q > COIL_LIMIT) begin clp = 1'b1; q = COIL_LIMIT; end
    end else if (hdr[1] == FC_READ_HOLDING || hdr[1] == FC_READ_INPUTREG ||
                 hdr[1] == FC_WRITE_REGS) begin
      if (q > REG_LIMIT) begin clp = 1'b1; q = REG_LIMIT; end
    end
    return q;
  endfunction

  function automatic void store_data_byte(logic [7:0] b);
    int d, base, q, e, ix;
    logic clp;
    d = data_cnt;
    base = {hdr[2], hdr[3]};
    q = limited_qty(clp);
    if (data_cnt < 4095) data_cnt++;
    if (d >= hdr[6]) return;
    if (hdr[1] == FC_WRITE_COILS) begin
      for (int j = 0; j < 8; j++) begin
        e = d * 8 + j;
        if (e < q) coil_mem[(base + e) % COIL_DEPTH] = b[j];
      end
    end else if (hdr[1] == FC_WRITE_REGS) begin
      e = d / 2;
      if (e < q) begin
        ix = (base + e) % REG_DEPTH;
        if (d % 2 == 0) hold_mem[ix][15:8] = b;
        else hold_mem[ix][7:0] = b;
      end
    end
  endfunction

  function automatic void close_request();
    int q;
    logic clp;
    flag_bad = 1'b0;
    flag_clip = 1'b0;
    flag_ready = 1'b0;
    if (!known_fc(hdr[1])) begin
      flag_bad = 1'b1;
      return;
    end
    q = limited_qty(clp);
    flag_clip = clp;
    if (hdr[1] <= FC_READ_INPUTREG) rsp_len = 8'(3 + (bit_fc(hdr[1]) ? (q + 7) / 8 : q * 2));
    else rsp_len = 8'd6;
    rsp_pos = '0;
    flag_ready = 1'b1;
  endfunction

  function automatic logic [7:0] reply_byte(int k);
    int base, q, e;
    logic clp;
    logic [7:0] v;
    logic [15:0] r;
    base = {hdr[2], hdr[3]};
    q = limited_qty(clp);
    if (k < 2) return hdr[k];
    if (hdr[1] > FC_READ_INPUTREG) return (k < 6) ? hdr[k] : 8'd0;
    if (k == 2) return rsp_len - 8'd3;
    k -= 3;
    if (bit_fc(hdr[1])) begin
      v = '0;
      for (int j = 0; j < 8; j++) begin
        e = k * 8 + j;
        if (e < q && coil_mem[(base + e) % COIL_DEPTH]) v[j] = 1'b1;
      end
      return v;
    end
    r = hold_mem[(base + k / 2) % REG_DEPTH];
    return (k % 2) ? r[7:0] : r[15:8];
  endfunction

  function automatic result_t model_step(item_t it);
    result_t r;
    r = '0;
    case (it.cmd)
      CMD_PUSH: begin
        if (hdr_pos == 0 && data_cnt == 0) begin
          foreach (hdr[i]) hdr[i] = '0;
          flag_ready = 1'b0;
        end
        if (hdr_pos < 7) begin
          hdr[hdr_pos] = it.data_byte;
          hdr_pos++;
        end else store_data_byte(it.data_byte);
        if (it.request_last) begin
          close_request();
          hdr_pos = 0;
          data_cnt = 0;
        end
      end
      CMD_PULL: begin
        if (flag_ready) begin
          r.out_byte = reply_byte(rsp_pos);
          r.out_valid = 1'b1;
          rsp_pos++;
          if (rsp_pos >= rsp_len) begin
            r.out_last = 1'b1;
            flag_ready = 1'b0;
          end
        end
      end
      CMD_HWRITE: begin
        if (it.store_select) coil_mem[it.entry_index % COIL_DEPTH] = it.entry_value[0];
        else hold_mem[it.entry_index % REG_DEPTH] = it.entry_value;
      end
      default: begin
        r.entry_read_value = it.store_select ? 16'(coil_mem[it.entry_index % COIL_DEPTH])
                                             : hold_mem[it.entry_index % REG_DEPTH];
      end
    endcase
    r.response_ready = flag_ready;
    r.bad_function = flag_bad;
    r.quantity_clipped = flag_clip;
    return r;
  endfunction

  function automatic item_t mk_item(cmd_e c, logic [7:0] b, logic last);
    item_t it;
    it = item_t'({$urandom, $urandom});
    it.cmd = c;
    it.data_byte = b;
    it.request_last = last;
    return it;
  endfunction

  function automatic item_t mk_host(cmd_e c, logic sel, logic [11:0] ix, logic [15:0] v);
    item_t it;
    it = mk_item(c, 8'($urandom), 1'($urandom));
    it.store_select = sel;
    it.entry_index = ix;
    it.entry_value = v;
    return it;
  endfunction

  task automatic send_item(item_t it, logic typed, result_t typed_res);
    result_t r;
    int gap;
    start_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy_o);
    r = model_step(it);
    pending_q.push_back(typed ? typed_res : r);
    sent++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send(item_t it);
    send_item(it, 1'b0, '0);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic random_request();
    logic [7:0] fc, bc;
    logic [7:0] bytes[$];
    int q, sel, nbytes, npull;
    logic [15:0] base, qty;
    sel = $urandom_range(0, 19);
    case (sel % 8)
      0: fc = FC_READ_COILS;
      1: fc = FC_READ_INPUTS;
      2: fc = FC_READ_HOLDING;
      3: fc = FC_READ_INPUTREG;
      4: fc = FC_WRITE_COIL;
      5: fc = FC_WRITE_REG;
      6: fc = FC_WRITE_COILS;
      default: fc = FC_WRITE_REGS;
    endcase
    if (sel >= 16) fc = 8'($urandom);
    base = 16'($urandom);
    case ($urandom_range(0, 99)) inside
      [0:79]: qty = 16'($urandom_range(1, 16));
      [80:87]: qty = 16'd0;
      [88:95]: qty = bit_fc(fc) ? 16'($urandom_range(17, 80)) : 16'($urandom_range(120, 130));
      [96:97]: qty = bit_fc(fc) ? 16'($urandom_range(1995, 2005)) : 16'($urandom);
      default: qty = 16'($urandom);
    endcase
    q = qty;
    if (bit_fc(fc) && q > COIL_LIMIT) q = COIL_LIMIT;
    if (!bit_fc(fc) && q > REG_LIMIT) q = REG_LIMIT;
    bytes = '{8'($urandom), fc, base[15:8], base[7:0], qty[15:8], qty[7:0]};
    if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
      nbytes = (fc == FC_WRITE_COILS) ? (q + 7) / 8 : q * 2;
      if (nbytes > 255) nbytes = 255;
      bc = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 20)) : 8'(nbytes);
      bytes.push_back(bc);
      nbytes = bc + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 0);
      repeat (nbytes) bytes.push_back(8'($urandom));
    end
    if ($urandom_range(0, 19) == 0) bytes = bytes[0:$urandom_range(0, bytes.size() - 1)];
    foreach (bytes[i]) begin
      send(mk_item(CMD_PUSH, bytes[i], i == bytes.size() - 1));
      if ($urandom_range(0, 29) == 0)
        send(mk_host(CMD_HREAD, 1'($urandom), 12'($urandom), 16'($urandom)));
    end
    if (fc <= FC_READ_INPUTREG) npull = 3 + (bit_fc(fc) ? (q + 7) / 8 : q * 2);
    else npull = 6;
    if ($urandom_range(0, 9) == 0) npull = $urandom_range(0, npull);
    npull += $urandom_range(0, 1);
    repeat (npull) begin
      if ($urandom_range(0, 9) == 0)
        send(mk_host(cmd_e'($urandom_range(2, 3)), 1'($urandom), 12'($urandom),
                     16'($urandom)));
      send(mk_item(CMD_PULL, 8'($urandom), 1'($urandom)));
    end
  endtask

  typedef struct {
    item_t   it;
    logic    typed;
    result_t res;
  } row_t;

  initial begin
    row_t       rows[$];
    result_t    bad_res;
    logic [7:0] seq[$];
    bad_res = '0;
    bad_res.bad_function = 1'b1;
    foreach (hold_mem[i]) hold_mem[i] = '0;
    foreach (coil_mem[i]) coil_mem[i] = 1'b0;
    foreach (hdr[i]) hdr[i] = '0;
    hdr_pos = 0;
    data_cnt = 0;
    rsp_len = '0;
    rsp_pos = '0;
    flag_bad = 1'b0;
    flag_clip = 1'b0;
    flag_ready = 1'b0;

    rows.push_back('{mk_host(CMD_HREAD, 1'b0, 12'd0, 16'hffff), 1'b1, result_t'('0)});
    rows.push_back('{mk_host(CMD_HREAD, 1'b1, 12'hfff, 16'h0000), 1'b1, result_t'('0)});
    rows.push_back('{mk_item(CMD_PULL, 8'hff, 1'b1), 1'b1, result_t'('0)});
    rows.push_back('{mk_host(CMD_HWRITE, 1'b0, 12'hfff, 16'hffff), 1'b0, '0});
    rows.push_back('{mk_host(CMD_HWRITE, 1'b1, 12'hfff, 16'h0001), 1'b0, '0});
    rows.push_back('{mk_host(CMD_HREAD, 1'b0, 12'h3ff, 16'h0000), 1'b0, '0});
    rows.push_back('{mk_item(CMD_PUSH, 8'h11, 1'b0), 1'b0, '0});
    rows.push_back('{mk_item(CMD_PUSH, 8'h00, 1'b1), 1'b1, bad_res});
    rows.push_back('{mk_item(CMD_PUSH, 8'hff, 1'b0), 1'b0, '0});
    rows.push_back('{mk_item(CMD_PUSH, 8'hff, 1'b1), 1'b1, bad_res});
    seq = '{8'h01, FC_READ_COILS, 8'h0f, 8'hff, 8'h00, 8'h09};
    foreach (seq[i])
      rows.push_back('{mk_item(CMD_PUSH, seq[i], i == seq.size() - 1), 1'b0, '0});
    repeat (6) rows.push_back('{mk_item(CMD_PULL, 8'h00, 1'b0), 1'b0, '0});
    seq = '{8'h02, FC_READ_HOLDING, 8'hff, 8'hff, 8'h00, 8'h7e};
    foreach (seq[i])
      rows.push_back('{mk_item(CMD_PUSH, seq[i], i == seq.size() - 1), 1'b0, '0});
    repeat (4) rows.push_back('{mk_item(CMD_PULL, 8'h00, 1'b0), 1'b0, '0});
    seq = '{8'h03, FC_WRITE_REGS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    foreach (seq[i])
      rows.push_back('{mk_item(CMD_PUSH, seq[i], i == seq.size() - 1), 1'b0, '0});
    rows.push_back('{mk_item(CMD_PULL, 8'h00, 1'b0), 1'b0, '0});
    rows.push_back('{mk_item(CMD_PUSH, 8'h04, 1'b0), 1'b0, '0});
    rows.push_back('{mk_item(CMD_PUSH, FC_WRITE_REG, 1'b1), 1'b0, '0});
    repeat (7) rows.push_back('{mk_item(CMD_PULL, 8'h00, 1'b0), 1'b0, '0});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);
    drain();
    while (sent < 1800) begin
      if ($urandom_range(0, 9) == 0)
        send(item_t'({$urandom, $urandom}));
      else random_request();
      if (sent > 900 && sent < 960) drain();
    end
    start_i <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("tb_modbus_server_pdu_responder_unit passed");
    else
      $display("tb_modbus_server_pdu_responder_unit failed");
    $finish;
  end

  always @(posedge clk_i) begin
    result_t want;
    if (done_o) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result_o);
      end else begin
        want = pending_q.pop_front();
        if (result_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("exp/act byte %h/%h v %b/%b l %b/%b r %b/%b b %b/%b c %b/%b rd %h/%h",
                     want.out_byte, result_o.out_byte, want.out_valid, result_o.out_valid,
                     want.out_last, result_o.out_last, want.response_ready,
                     result_o.response_ready, want.bad_function, result_o.bad_function,
                     want.quantity_clipped, result_o.quantity_clipped,
                     want.entry_read_value, result_o.entry_read_value);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("tb_modbus_server_pdu_responder_unit failed");
    $finish;
  end

endmodule
